### rtl/cdq_pkg.sv
// Shared constants, codes and types for the circular deque.
// No dependencies; every other file except cdq_ram imports this package.
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int ERR_W  = 2;
  localparam int CAP_W  = 5;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STATUS     = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Controller to datapath commands.
  typedef struct packed {
    logic step;     // apply the accepted transaction to indices, count and storage
    logic load_rd;  // capture front and rear entries from storage
  } cmd_t;

endpackage

### rtl/cdq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Standalone; no package dependency.
module cdq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/cdq_ctrl.sv
// Controller: sequences accept, storage read and result hand-off.
// Depends on cdq_pkg for the command struct.
module cdq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cdq_pkg::cmd_t  cmd_o
);
  import cdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d       = state_q;
    cmd_o.step    = 1'b0;
    cmd_o.load_rd = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.load_rd = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // hold the result until the consumer takes it
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/cdq_dp.sv
// Datapath: capacity register, front/rear indices, entry count, storage RAM.
// Depends on cdq_pkg and cdq_ram.
module cdq_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cdq_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  cdq_pkg::cmd_t                cmd_i,
  input  logic [cdq_pkg::ACT_W-1:0]    action_i,
  input  logic signed [cdq_pkg::DATA_W-1:0] value_i,
  output logic signed [cdq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [cdq_pkg::DATA_W-1:0] rear_value_o,
  output logic [cdq_pkg::CNT_W-1:0]    occupancy_o,
  output logic                         is_empty_o,
  output logic                         is_full_o,
  output logic [cdq_pkg::ERR_W-1:0]    error_code_o
);
  import cdq_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [IDX_W-1:0]  rear_q, rear_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ERR_W-1:0]  err_q, err_d;
  logic [CNT_W-1:0]  eff_cap;
  logic [IDX_W-1:0]  cap_m1;
  logic [IDX_W-1:0]  front_dec, front_inc, rear_dec, rear_inc;
  logic              is_push, is_pop, wr_en;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] rd_front, rd_rear;

  // clamp the register to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  assign cap_m1    = IDX_W'(eff_cap - CNT_W'(1));
  assign front_dec = (front_q == '0) ? cap_m1 : front_q - IDX_W'(1);
  assign front_inc = (front_q >= cap_m1) ? '0 : front_q + IDX_W'(1);
  assign rear_dec  = (rear_q == '0) ? cap_m1 : rear_q - IDX_W'(1);
  assign rear_inc  = (rear_q >= cap_m1) ? '0 : rear_q + IDX_W'(1);

  assign is_push = (action_i == ACT_PUSH_FRONT) || (action_i == ACT_PUSH_REAR);
  assign is_pop  = (action_i == ACT_POP_FRONT) || (action_i == ACT_POP_REAR);

  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    cnt_d   = cnt_q;
    err_d   = ERR_OK;
    wr_en   = 1'b0;
    if (is_push && (cnt_q >= eff_cap)) begin
      err_d = ERR_FULL;
    end else if (is_pop && (cnt_q == '0)) begin
      err_d = ERR_EMPTY;
    end else if (is_push) begin
      // an empty deque takes its first entry at index zero without moving
      if (cnt_q != '0) begin
        if (action_i == ACT_PUSH_FRONT) begin
          front_d = front_dec;
        end else begin
          rear_d = rear_inc;
        end
      end
      wr_en = 1'b1;
      cnt_d = cnt_q + CNT_W'(1);
    end else if (is_pop) begin
      if (cnt_q == CNT_W'(1)) begin
        front_d = '0;
        rear_d  = '0;
        cnt_d   = '0;
      end else begin
        if (action_i == ACT_POP_FRONT) begin
          front_d = front_inc;
        end else begin
          rear_d = rear_dec;
        end
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  assign waddr = (action_i == ACT_PUSH_FRONT) ? front_d : rear_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      front_q <= '0;
      rear_q  <= '0;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      // a new capacity empties the deque
      cap_q   <= cfg_wdata_i;
      front_q <= '0;
      rear_q  <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.step) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      err_q <= err_d;
    end
  end

  cdq_ram #(
    .Width (DATA_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.step && wr_en),
    .waddr_i   (waddr),
    .wdata_i   (value_i),
    .re_i      (cmd_i.load_rd),
    .raddr_a_i (front_q),
    .raddr_b_i (rear_q),
    .rdata_a_o (rd_front),
    .rdata_b_o (rd_rear)
  );

  assign is_empty_o    = (cnt_q == '0);
  assign is_full_o     = (cnt_q == eff_cap);
  assign occupancy_o   = cnt_q;
  assign error_code_o  = err_q;
  assign front_value_o = is_empty_o ? '0 : $signed(rd_front);
  assign rear_value_o  = is_empty_o ? '0 : $signed(rd_rear);

endmodule

### rtl/circular_deque.sv
// Top level of the circular deque: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp (and cdq_ram below it).
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------------
//   cfg     | in        | cfg_we_i                   | cfg_wdata_i (capacity)
//   in      | in        | in_valid_i / in_stall_o    | action_i, value_i
//   out     | out       | out_valid_o / out_stall_i  | front/rear value, occupancy, flags, error
//
// Each transaction passes an accept state that updates indices and writes
// storage, a read state for the registered RAM read of front and rear, and
// a result state held through any output stall. The next transaction is
// accepted once the result is taken. Reset leaves the deque empty with
// capacity 16; a capacity write also empties it.
module circular_deque (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cdq_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cdq_pkg::ACT_W-1:0]         action_i,
  input  logic signed [cdq_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cdq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [cdq_pkg::DATA_W-1:0] rear_value_o,
  output logic [cdq_pkg::CNT_W-1:0]         occupancy_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic [cdq_pkg::ERR_W-1:0]         error_code_o
);
  import cdq_pkg::*;

  cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  cdq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .action_i      (action_i),
    .value_i       (value_i),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .occupancy_o   (occupancy_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .error_code_o  (error_code_o)
  );

endmodule
